// ===== rtl/core/rvc_pkg.sv =====
// Package for the rotary encoder volume control: widths, reset values,
// register indexes, the configuration struct and small helper functions.
// No dependencies.
package rvc_pkg;

	localparam int VolWidth   = 8;
	localparam int HoldWidth  = 11;
	localparam int TickWidth  = 10;
	localparam int ReqWidth   = 16;
	localparam int CfgIdxWidth  = 3;
	localparam int CfgDataWidth = 10;

	localparam logic [VolWidth-1:0]  VolumeReset   = 8'd50;
	localparam logic [VolWidth-1:0]  VolMinReset   = 8'd0;
	localparam logic [VolWidth-1:0]  VolMaxReset   = 8'd100;
	localparam logic [VolWidth-1:0]  VolStepReset  = 8'd5;
	localparam logic [TickWidth-1:0] RotHoldReset  = 10'd20;
	localparam logic [TickWidth-1:0] BtnHoldReset  = 10'd200;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_VOL_FLOOR = 3'd0,
		REG_VOL_CEIL  = 3'd1,
		REG_VOL_INCR  = 3'd2,
		REG_ROT_HOLD  = 3'd3,
		REG_BTN_HOLD  = 3'd4
	} reg_idx_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_SET  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [VolWidth-1:0]  vol_floor;
		logic [VolWidth-1:0]  vol_ceil;
		logic [VolWidth-1:0]  vol_incr;
		logic [TickWidth-1:0] rotation_hold_ticks;
		logic [TickWidth-1:0] button_hold_ticks;
	} cfg_t;

	// saturating add of a tick count onto the hold counter
	function automatic logic [HoldWidth-1:0] hold_add(
		input logic [HoldWidth-1:0] h,
		input logic [TickWidth-1:0] n
	);
		logic [HoldWidth:0] s;
		s = {1'b0, h} + (HoldWidth+1)'(n);
		hold_add = s[HoldWidth] ? {HoldWidth{1'b1}} : s[HoldWidth-1:0];
	endfunction

endpackage

// ===== rtl/core/rvc_if.sv =====
// Channel interfaces for the rotary encoder volume control: tick/command
// input, result output and configuration write channel. Depends on rvc_pkg.
interface rvc_in_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic                          level_a;
	logic                          level_b;
	logic                          level_button;
	logic signed [rvc_pkg::ReqWidth-1:0] req_volume;

	modport source (output valid, cmd, level_a, level_b, level_button, req_volume,
		input ready);
	modport sink (input valid, cmd, level_a, level_b, level_button, req_volume,
		output ready);
endinterface

interface rvc_out_if;
	logic                          valid;
	logic                          ready;
	logic [rvc_pkg::VolWidth-1:0]  volume;
	logic                          turn_event;
	logic                          button_press;

	modport source (output valid, volume, turn_event, button_press, input ready);
	modport sink (input valid, volume, turn_event, button_press, output ready);
endinterface

interface rvc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rvc_pkg::CfgIdxWidth-1:0]   index;
	logic [rvc_pkg::CfgDataWidth-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rvc_cfg_regs.sv =====
// Configuration register file for the volume control.
// Depends on rvc_pkg and rvc_cfg_if.
module rvc_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	rvc_cfg_if.sink       cfg,
	output rvc_pkg::cfg_t regs
);
	import rvc_pkg::*;

	cfg_t regs_q;
	logic wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.vol_floor           <= VolMinReset;
			regs_q.vol_ceil            <= VolMaxReset;
			regs_q.vol_incr            <= VolStepReset;
			regs_q.rotation_hold_ticks <= RotHoldReset;
			regs_q.button_hold_ticks   <= BtnHoldReset;
		end else if (wr) begin
			// indexes past the list are dropped
			unique case (cfg.index)
				REG_VOL_FLOOR: regs_q.vol_floor <= cfg.data[VolWidth-1:0];
				REG_VOL_CEIL:  regs_q.vol_ceil  <= cfg.data[VolWidth-1:0];
				REG_VOL_INCR:  regs_q.vol_incr  <= cfg.data[VolWidth-1:0];
				REG_ROT_HOLD:  regs_q.rotation_hold_ticks <= cfg.data[TickWidth-1:0];
				REG_BTN_HOLD:  regs_q.button_hold_ticks   <= cfg.data[TickWidth-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/rvc_core.sv =====
// Input register, single-pass decode/volume logic and result register.
// Depends on rvc_pkg, rvc_in_if and rvc_out_if.
module rvc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  rvc_pkg::cfg_t regs,
	rvc_in_if.sink        items,
	rvc_out_if.source     results
);
	import rvc_pkg::*;

	// stage 1: captured transaction
	logic                        valid_s1;
	logic                        cmd_s1;
	logic                        a_s1;
	logic                        b_s1;
	logic                        btn_s1;
	logic signed [ReqWidth-1:0]  req_s1;

	// stage 2: result register
	logic                        valid_s2;
	logic [VolWidth-1:0]         vol_s2;
	logic                        turn_s2;
	logic                        press_s2;

	// block state
	logic [VolWidth-1:0]         volume_q;
	logic                        prev_a_q;
	logic                        prev_btn_q;
	logic [HoldWidth-1:0]        hold_q;

	logic                        out_free;
	logic                        fire;
	logic                        accept;

	logic [VolWidth-1:0]         vol_nxt;
	logic                        prev_a_nxt;
	logic                        prev_btn_nxt;
	logic [HoldWidth-1:0]        hold_nxt;
	logic [HoldWidth-1:0]        hold_dec;
	logic [HoldWidth-1:0]        hold_rot;
	logic                        turn_nxt;
	logic                        press_nxt;
	logic                        detent;
	logic                        btn_fall;

	logic signed [ReqWidth:0]    req_ext;
	logic signed [ReqWidth:0]    lo_ext;
	logic signed [ReqWidth:0]    hi_ext;
	logic signed [ReqWidth:0]    set_lo;
	logic [VolWidth-1:0]         set_vol;

	logic [VolWidth:0]           up_sum;
	logic signed [VolWidth+1:0]  dn_diff;
	logic [VolWidth-1:0]         turn_vol;

	assign out_free    = !valid_s2 || results.ready;
	assign fire        = valid_s1 && out_free;
	assign items.ready = !valid_s1 || out_free;
	assign accept      = items.valid && items.ready;

	// set command clamp: raise to floor, then lower to ceiling
	assign req_ext = {req_s1[ReqWidth-1], req_s1};
	assign lo_ext  = $signed({{(ReqWidth+1-VolWidth){1'b0}}, regs.vol_floor});
	assign hi_ext  = $signed({{(ReqWidth+1-VolWidth){1'b0}}, regs.vol_ceil});
	assign set_lo  = (req_ext < lo_ext) ? lo_ext : req_ext;
	assign set_vol = (set_lo > hi_ext) ? regs.vol_ceil : set_lo[VolWidth-1:0];

	// detent step, saturating at the limits
	assign up_sum  = {1'b0, volume_q} + {1'b0, regs.vol_incr};
	assign dn_diff = $signed({2'b00, volume_q}) - $signed({2'b00, regs.vol_incr});

	always_comb begin
		turn_vol = volume_q;
		if (b_s1 && (volume_q < regs.vol_ceil)) begin
			turn_vol = (up_sum > {1'b0, regs.vol_ceil}) ? regs.vol_ceil
				: up_sum[VolWidth-1:0];
		end else if (!b_s1 && (volume_q > regs.vol_floor)) begin
			turn_vol = (dn_diff < $signed({2'b00, regs.vol_floor})) ? regs.vol_floor
				: dn_diff[VolWidth-1:0];
		end
	end

	assign detent   = prev_a_q && !a_s1;
	assign btn_fall = prev_btn_q && !btn_s1;
	assign hold_dec = hold_q - HoldWidth'(1);
	assign hold_rot = detent ? hold_add(hold_q, regs.rotation_hold_ticks) : hold_q;

	always_comb begin
		vol_nxt      = volume_q;
		prev_a_nxt   = prev_a_q;
		prev_btn_nxt = prev_btn_q;
		hold_nxt     = hold_q;
		turn_nxt     = 1'b0;
		press_nxt    = 1'b0;
		if (cmd_s1 == CMD_SET) begin
			vol_nxt = set_vol;
		end else if (hold_q != '0) begin
			// count down; relatch levels on the last held tick
			hold_nxt = hold_dec;
			if (hold_dec == '0) begin
				prev_a_nxt   = a_s1;
				prev_btn_nxt = btn_s1;
			end
		end else begin
			turn_nxt     = detent;
			press_nxt    = btn_fall;
			vol_nxt      = detent ? turn_vol : volume_q;
			hold_nxt     = btn_fall ? hold_add(hold_rot, regs.button_hold_ticks) : hold_rot;
			prev_a_nxt   = a_s1;
			prev_btn_nxt = btn_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			volume_q   <= VolumeReset;
			prev_a_q   <= 1'b1;
			prev_btn_q <= 1'b1;
			hold_q     <= '0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				volume_q   <= vol_nxt;
				prev_a_q   <= prev_a_nxt;
				prev_btn_q <= prev_btn_nxt;
				hold_q     <= hold_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= items.cmd;
			a_s1   <= items.level_a;
			b_s1   <= items.level_b;
			btn_s1 <= items.level_button;
			req_s1 <= items.req_volume;
		end
		if (fire) begin
			vol_s2   <= vol_nxt;
			turn_s2  <= turn_nxt;
			press_s2 <= press_nxt;
		end
	end

	assign results.valid        = valid_s2;
	assign results.volume       = vol_s2;
	assign results.turn_event   = turn_s2;
	assign results.button_press = press_s2;

endmodule

// ===== rtl/core/rotary_encoder_volume_control.sv =====
// Top level of the rotary encoder volume control.
// Depends on rvc_pkg, rvc_if.sv, rvc_cfg_regs and rvc_core.
//
// Each input transaction is either a poll tick carrying sampled levels of
// encoder channels A and B and of the push button (idle high, pressed low),
// or a set command carrying a signed requested volume. Every input
// transaction yields exactly one result transaction with the volume after
// that item, a turn flag and a button-press flag. A falling edge of A while
// no hold is running is a detent: B high steps the volume up, B low steps it
// down, saturating at the volume floor / ceiling, and a rotation hold starts.
// A falling button edge in such a tick flags a press and adds a button hold.
// While a hold runs, ticks only count it down; on the tick it reaches zero,
// the stored previous levels take that tick's levels. A set command clamps
// the request (raised to the floor, then lowered to the ceiling, so the
// ceiling wins if the limits cross) and touches nothing but the volume.
// Timing: an accepted transaction lands in the input register, is resolved
// by one pass of combinational logic against the volume/hold state, and its
// result is registered. While results are taken, one transaction per clock
// sustained. The input side keeps accepting while a result waits, as long
// as the result register drains. Configuration writes are taken every cycle
// (ready tied high) and should only be issued while the block is idle.
module rotary_encoder_volume_control (
	input  logic      clk,
	input  logic      arst_n,
	rvc_cfg_if.sink   cfg,
	rvc_in_if.sink    items,
	rvc_out_if.source results
);
	import rvc_pkg::*;

	cfg_t regs;

	// register file: volume limits, step and hold lengths
	rvc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// input register, decode and result register
	rvc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.items   (items),
		.results (results)
	);

endmodule
